/* src/atp_pkg.sv */
// Package for the AT command parser: command tokens, opcodes, result kinds
// and the reply text. No dependencies; every module of the block imports it.
package atp_pkg;

    // Bound on the count of command text bytes that follow the header.
    localparam int BUF_DEPTH = 16;
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);

    // Only the first six command characters ever decide a match.
    localparam int TEXT_LEN  = 6;
    localparam int TEXT_AW   = $clog2(TEXT_LEN);

    // Command queue between the front and the back end.
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // Result kinds.
    localparam logic [1:0] KIND_CH    = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    // Command opcodes carried by the queue.
    localparam logic [1:0] OP_CH  = 2'd0;
    localparam logic [1:0] OP_ACK = 2'd1;
    localparam logic [1:0] OP_ASK = 2'd2;

    // ASCII characters used by the matcher.
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_H     = 8'h48;
    localparam logic [7:0] CHR_K     = 8'h4B;
    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_QM    = 8'h3F;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;

    // (d0-'0')*100 + (d1-'0')*10 + (d2-'0') mod 256 folds into +48.
    localparam logic [7:0] CH_BIAS   = 8'd48;

    // Reply sequence: "NOACK" "CH=" then three digits. Starting at index
    // two skips "NO" and gives "ACK".
    localparam int         REPLY_FIXED = 8;
    localparam logic [3:0] IDX_NOACK   = 4'd0;
    localparam logic [3:0] IDX_ACK     = 4'd2;
    localparam logic [3:0] IDX_LAST    = 4'd10;

    localparam logic [7:0] REPLY_TEXT [REPLY_FIXED] = '{
        8'h4E, 8'h4F, 8'h41, 8'h43, 8'h4B, 8'h43, 8'h48, 8'h3D
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
    } t_cmd;

endpackage

/* src/atp_front.sv */
// Front end of the AT command parser: header matcher, command text capture
// and command classification. Depends on atp_pkg.
module atp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output atp_pkg::t_cmd o_cmd
);
    import atp_pkg::*;

    logic [1:0]        r_head_pos, n_head_pos;
    logic              r_in_cmd,   n_in_cmd;
    logic [FILL_W-1:0] r_fill,     n_fill;
    logic [7:0]        r_text [TEXT_LEN];
    logic [7:0]        n_text [TEXT_LEN];
    logic [7:0]        head_chr;
    logic              head_done;
    logic              ch_hit, ack_hit, ask_hit;

    always_comb begin
        case (r_head_pos)
            2'd0:    head_chr = CHR_A;
            2'd1:    head_chr = CHR_T;
            default: head_chr = CHR_PLUS;
        endcase
    end

    always_comb begin
        // The byte is stored first, with the count as it stood.
        for (int i = 0; i < TEXT_LEN; i++) begin
            n_text[i] = r_text[i];
        end
        n_fill = r_fill;
        if (r_in_cmd && r_fill < FILL_W'(BUF_DEPTH)) begin
            n_fill = r_fill + FILL_W'(1);
            if (r_fill < FILL_W'(TEXT_LEN)) begin
                n_text[r_fill[TEXT_AW-1:0]] = i_rx_byte;
            end
        end

        // Header matcher; a mismatch drops back without rechecking the byte.
        head_done  = 1'b0;
        n_head_pos = 2'd0;
        if (i_rx_byte == head_chr) begin
            if (r_head_pos == 2'd2) begin
                head_done = 1'b1;
            end else begin
                n_head_pos = r_head_pos + 2'd1;
            end
        end
        n_in_cmd = r_in_cmd;
        if (head_done) begin
            n_in_cmd = 1'b1;
            n_fill   = '0;
        end

        ch_hit  = n_in_cmd && n_fill >= FILL_W'(TEXT_LEN)
                  && n_text[0] == CHR_C && n_text[1] == CHR_H && n_text[2] == CHR_EQ;
        ack_hit = n_in_cmd && n_fill >= FILL_W'(TEXT_LEN)
                  && n_text[0] == CHR_A && n_text[1] == CHR_C
                  && n_text[2] == CHR_K && n_text[3] == CHR_EQ;
        ask_hit = n_in_cmd && n_fill >= FILL_W'(2)
                  && n_text[0] == CHR_QM && n_text[1] == CHR_EQ;

        o_push    = 1'b0;
        o_cmd.op  = OP_ASK;
        o_cmd.d0  = n_text[3];
        o_cmd.d1  = n_text[4];
        o_cmd.d2  = n_text[5];
        if (ch_hit) begin
            n_in_cmd = 1'b0;
            o_push   = i_accept;
            o_cmd.op = OP_CH;
        end else if (ack_hit) begin
            // An auto-ack value other than '0' or '1' ends the command silently.
            n_in_cmd = 1'b0;
            o_push   = i_accept && (n_text[4] == CHR_ONE || n_text[4] == CHR_ZERO);
            o_cmd.op = OP_ACK;
            o_cmd.d0 = {7'd0, n_text[4] == CHR_ONE};
        end else if (ask_hit) begin
            n_in_cmd = 1'b0;
            o_push   = i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_pos <= 2'd0;
            r_in_cmd   <= 1'b0;
            r_fill     <= '0;
        end else if (i_accept) begin
            r_head_pos <= n_head_pos;
            r_in_cmd   <= n_in_cmd;
            r_fill     <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < TEXT_LEN; i++) begin
                r_text[i] <= n_text[i];
            end
        end
    end

endmodule

/* src/atp_queue.sv */
// Short command queue between the front and the back end of the AT command
// parser. Depends on atp_pkg.
module atp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  atp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output atp_pkg::t_cmd o_cmd
);
    import atp_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = r_count == Q_CW'(Q_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= Q_AW'((int'(r_wr) + 1) % Q_DEPTH);
            end
            if (do_pop) begin
                r_rd <= Q_AW'((int'(r_rd) + 1) % Q_DEPTH);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

/* src/atp_back.sv */
// Back end of the AT command parser: holds channel and auto-ack, executes
// queued commands and streams reply characters. Depends on atp_pkg.
module atp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  atp_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [7:0]    o_value,
    output logic          o_last
);
    import atp_pkg::*;

    logic [7:0]  r_channel;
    logic        r_auto_ack;
    logic        r_busy;
    logic [3:0]  r_idx;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_value;
    logic        r_last;

    logic        out_free;
    logic [7:0]  new_ch;
    logic [3:0]  start_idx;
    logic [3:0]  cur_idx;
    logic [7:0]  cur_chr;
    logic [7:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  ones;
    logic [7:0]  hund_chr, tens_chr, ones_chr;

    assign out_free  = !r_valid || i_ready;
    assign o_pop     = out_free && !r_busy && i_cmd_valid;
    assign new_ch    = 8'(i_cmd.d0 * 8'd100) + 8'(i_cmd.d1 * 8'd10) + i_cmd.d2 + CH_BIAS;
    assign start_idx = r_auto_ack ? IDX_ACK : IDX_NOACK;
    assign cur_idx   = r_busy ? r_idx : start_idx;

    // Decimal digits of the channel: compare for hundreds, reciprocal for tens.
    always_comb begin
        if (r_channel >= 8'd200) begin
            hund_chr = CHR_ZERO + 8'd2;
            rem      = r_channel - 8'd200;
        end else if (r_channel >= 8'd100) begin
            hund_chr = CHR_ONE;
            rem      = r_channel - 8'd100;
        end else begin
            hund_chr = CHR_ZERO;
            rem      = r_channel;
        end
        prod     = 15'(rem[6:0]) * 15'd205;
        tens     = prod[14:11];
        ones     = rem - 8'({4'd0, tens} * 8'd10);
        tens_chr = CHR_ZERO + {4'd0, tens};
        ones_chr = CHR_ZERO + ones;
    end

    always_comb begin
        case (cur_idx)
            4'd8:    cur_chr = hund_chr;
            4'd9:    cur_chr = tens_chr;
            4'd10:   cur_chr = ones_chr;
            default: cur_chr = REPLY_TEXT[cur_idx[2:0]];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel  <= 8'd2;
            r_auto_ack <= 1'b1;
            r_busy     <= 1'b0;
            r_idx      <= 4'd0;
            r_valid    <= 1'b0;
        end else if (out_free) begin
            if (r_busy) begin
                r_valid <= 1'b1;
                r_idx   <= r_idx + 4'd1;
                if (r_idx == IDX_LAST) begin
                    r_busy <= 1'b0;
                end
            end else if (i_cmd_valid) begin
                r_valid <= 1'b1;
                case (i_cmd.op)
                    OP_CH: begin
                        r_channel <= new_ch;
                    end
                    OP_ACK: begin
                        r_auto_ack <= i_cmd.d0[0];
                    end
                    default: begin
                        r_busy <= 1'b1;
                        r_idx  <= start_idx + 4'd1;
                    end
                endcase
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_busy) begin
                r_kind  <= KIND_REPLY;
                r_value <= cur_chr;
                r_last  <= r_idx == IDX_LAST;
            end else begin
                case (i_cmd.op)
                    OP_CH: begin
                        r_kind  <= KIND_CH;
                        r_value <= new_ch;
                        r_last  <= 1'b1;
                    end
                    OP_ACK: begin
                        r_kind  <= KIND_ACK;
                        r_value <= {7'd0, i_cmd.d0[0]};
                        r_last  <= 1'b1;
                    end
                    default: begin
                        r_kind  <= KIND_REPLY;
                        r_value <= cur_chr;
                        r_last  <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_value = r_value;
    assign o_last  = r_last;

endmodule

/* src/at_command_parser.sv */
// Top level of the AT command parser: front end, command queue, back end.
// Depends on atp_pkg, atp_front, atp_queue and atp_back.
//
// The parser takes one received serial byte per beat and watches for the
// header "AT+". After the header it captures command text and, after every
// byte, tests for "CH=ddd" (sets the channel, digits unchecked, value taken
// mod 256), "ACK=b?" (sets auto-ack for '1', clears it for '0', anything
// else ends the command quietly) and "?=" (status reply). A match ends the
// command; a new header at any time restarts it. Channel and auto-ack reset
// to 2 and 1. Each event leaves as one result beat: kind 0 carries the new
// channel, kind 1 the new auto-ack flag, and kind 2 one reply character;
// a status reply is "ACK" or "NOACK", then "CH=", then three decimal digits,
// that is 9 or 11 beats, with o_last marking the final beat of each command.
// An input byte is classified in the cycle it is accepted, so bytes are
// taken back to back, one per cycle. Recognized commands wait in a
// four-entry queue; the back end drains them and emits one result beat per
// cycle while the output side is ready. The input stalls only when that
// queue is full. That happens when commands are recognized faster than
// their results drain: behind a stalled output, or when status requests
// follow each other closer than their 9 or 11 reply beats, since a request
// takes only five input bytes. There is no clearing pass after reset.
module at_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic       o_last
);
    import atp_pkg::*;

    logic  q_full;
    logic  q_valid;
    logic  cmd_push;
    logic  cmd_pop;
    logic  in_accept;
    t_cmd  push_cmd;
    t_cmd  head_cmd;

    // The front end never waits on anything but room in the queue.
    assign o_ready   = !q_full;
    assign in_accept = i_valid && o_ready;

    atp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (cmd_push),
        .o_cmd     (push_cmd)
    );

    atp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .i_pop   (cmd_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    atp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last)
    );

    // Channel and auto-ack results stand alone and always close their command.
    a_single_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_REPLY |-> o_last)
        else $error("channel or auto-ack result without last");

    // Only the three defined kinds leave the block; auto-ack values are 0 or 1.
    a_kind_value : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind == KIND_CH || o_kind == KIND_REPLY
                     || (o_kind == KIND_ACK && o_value[7:1] == 7'd0)))
        else $error("bad result kind or auto-ack value");

    // A reply streams without gaps: a taken non-final beat is followed by another.
    a_reply_stream : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_kind == KIND_REPLY)
        else $error("gap or wrong kind inside a reply");

    // A queued command is never pushed into a full queue.
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !q_full)
        else $error("command pushed into a full queue");

endmodule

/* sim/at_command_parser_checker.sv */
`timescale 1ns / 1ps
// Result checker for the AT command parser: predicts result beats from accepted input beats.
// Depends on atp_pkg for the result kinds, the ASCII codes and the buffer depth.
module at_command_parser_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_value,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending
);
    import atp_pkg::*;

    localparam int         MAX_BEATS  = 11;
    localparam logic [7:0] HEADER [3] = '{CHR_A, CHR_T, CHR_PLUS};
    localparam logic [39:0] NOACK_WORD = "NOACK";
    localparam logic [23:0] CH_WORD    = "CH=";

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } t_result;

    t_result due_results [$];

    // Shadow copy of the parser state.
    logic [1:0]        hdr_pos;
    logic              cmd_open;
    logic [FILL_W-1:0] fill;
    logic [7:0]        text [BUF_DEPTH];
    logic [7:0]        channel;
    logic              auto_ack;
    int                fails = 0;

    // Results of the byte being parsed, gathered before they are queued.
    logic [1:0] new_kind  [MAX_BEATS];
    logic [7:0] new_value [MAX_BEATS];
    int         new_count;

    task automatic flag_mismatch(input string msg);
        fails++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic note_result(input logic [1:0] kind, input logic [7:0] value);
        new_kind[new_count]  = kind;
        new_value[new_count] = value;
        new_count++;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int v;
        new_count = 0;
        // The byte is stored before the header matcher sees it.
        if (cmd_open && fill < BUF_DEPTH) begin
            text[fill] = b;
            fill++;
        end
        // A mismatch drops back to the start without retrying this byte.
        if (b == HEADER[hdr_pos]) hdr_pos++;
        else hdr_pos = 2'd0;
        if (hdr_pos == 3) begin
            cmd_open = 1'b1;
            hdr_pos  = 2'd0;
            fill     = '0;
        end
        if (cmd_open) begin
            if (fill >= 6 && text[0] == CHR_C && text[1] == CHR_H && text[2] == CHR_EQ) begin
                v = (int'(text[3]) - int'(CHR_ZERO)) * 100
                  + (int'(text[4]) - int'(CHR_ZERO)) * 10
                  + (int'(text[5]) - int'(CHR_ZERO));
                cmd_open = 1'b0;
                channel  = v[7:0];
                note_result(KIND_CH, channel);
            end else if (fill >= 6 && text[0] == CHR_A && text[1] == CHR_C
                         && text[2] == CHR_K && text[3] == CHR_EQ) begin
                cmd_open = 1'b0;
                if (text[4] == CHR_ONE) begin
                    auto_ack = 1'b1;
                    note_result(KIND_ACK, 8'd1);
                end else if (text[4] == CHR_ZERO) begin
                    auto_ack = 1'b0;
                    note_result(KIND_ACK, 8'd0);
                end
            end else if (fill >= 2 && text[0] == CHR_QM && text[1] == CHR_EQ) begin
                cmd_open = 1'b0;
                // "ACK" is the tail of "NOACK".
                for (int i = auto_ack ? 2 : 0; i < 5; i++)
                    note_result(KIND_REPLY, NOACK_WORD[8*(4-i) +: 8]);
                for (int i = 0; i < 3; i++)
                    note_result(KIND_REPLY, CH_WORD[8*(2-i) +: 8]);
                note_result(KIND_REPLY, channel / 8'd100 + CHR_ZERO);
                note_result(KIND_REPLY, channel % 8'd100 / 8'd10 + CHR_ZERO);
                note_result(KIND_REPLY, channel % 8'd10 + CHR_ZERO);
            end
        end
        for (int i = 0; i < new_count; i++)
            due_results.push_back('{new_kind[i], new_value[i], i == new_count - 1});
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            hdr_pos  = 2'd0;
            cmd_open = 1'b0;
            fill     = '0;
            channel  = 8'd2;
            auto_ack = 1'b1;
            foreach (text[i]) text[i] = 8'h00;
            due_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) parse_byte(i_rx_byte);
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat kind %0d value 0x%02h last %0b",
                                            i_kind, i_value, i_last));
                end else begin
                    want = due_results.pop_front();
                    if (i_kind !== want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d", i_kind, want.kind));
                    if (i_value !== want.value)
                        flag_mismatch($sformatf("value 0x%02h, expected 0x%02h",
                                                i_value, want.value));
                    if (i_last !== want.last)
                        flag_mismatch($sformatf("last %0b, expected %0b", i_last, want.last));
                end
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fails;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Top of the AT command parser testbench: clock, reset, byte stimulus and verdict.
// Depends on atp_pkg, at_command_parser and at_command_parser_checker.
module testbench;
    import atp_pkg::*;

    // Input bytes to send in all, the directed part included; the random part
    // stops once this many have been taken.
    localparam int ITEM_GOAL    = 460;
    localparam int IDLE_PCT     = 34;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'h00;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic       o_last;

    int   fail_count;
    int   pending;
    int   sent    = 0;
    // While steady is high neither side idles, so back-to-back beats get exercised.
    logic steady  = 1'b0;
    logic [7:0] burst [$];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    at_command_parser dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_kind),
        .o_value   (o_value),
        .o_last    (o_last)
    );

    at_command_parser_checker u_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_kind       (o_kind),
        .i_value      (o_value),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The result side stalls at random, except inside the steady window. A stalled
    // output lets replies back up until the parser's command queue fills and the
    // input side sees backpressure.
    always @(posedge i_clk) begin
        i_ready <= i_rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    // Presents one byte and returns at the edge where the beat is taken. Valid is
    // left high, so the next call either replaces the byte or lowers valid itself.
    task automatic send_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        steady <= (sent >= 200 && sent < 320);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) burst.push_back(s[i]);
    endtask

    task automatic push_noise(input int count);
        repeat (count) burst.push_back(8'($urandom_range(255)));
    endtask

    // Holds the input idle until every predicted result beat has come out.
    // The first edge lets the checker register the last accepted byte.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Channel digits are mostly decimal but the parser does not check them.
    function automatic logic [7:0] pick_digit();
        logic [7:0] d;
        if ($urandom_range(99) < 85) d = CHR_ZERO + 8'($urandom_range(9));
        else d = 8'($urandom_range(255));
        return d;
    endfunction

    function automatic logic [7:0] pick_flag();
        int r;
        r = $urandom_range(99);
        if (r < 40) return CHR_ONE;
        if (r < 80) return CHR_ZERO;
        return 8'($urandom_range(255));
    endfunction

    initial begin
        int  pick;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Both extreme byte values are plain noise outside a command.
        send_byte(8'h00);
        send_byte(8'hFF);
        // The second 'A' breaks the match and is not retried as a first header byte,
        // so this header is missed.
        send_text("AAT+");
        // A header in the middle of a command restarts it; the status reply follows
        // with the reset channel and auto-ack on.
        send_text("AT+CAT+?=");
        // 999 wraps modulo 256.
        send_text("AT+CH=999");
        wait_drained();

        // Random part: mostly complete commands with random content, the rest noise
        // and sequences cut short.
        while (sent < ITEM_GOAL) begin
            pick  = $urandom_range(99);
            if (pick < 22) begin
                push_text("AT+CH=");
                repeat (3) burst.push_back(pick_digit());
            end else if (pick < 42) begin
                push_text("AT+ACK=");
                burst.push_back(pick_flag());
                burst.push_back(8'($urandom_range(255)));
            end else if (pick < 62) begin
                push_text("AT+?=");
            end else if (pick < 70) begin
                // Overlong text fills the store and then keeps waiting for a header.
                push_text("AT+X");
                push_noise($urandom_range(16, 19));
            end else if (pick < 85) begin
                push_noise($urandom_range(1, 6));
            end else begin
                case ($urandom_range(6))
                    0: push_text("A");
                    1: push_text("AT");
                    2: push_text("AAT+");
                    3: push_text("AT+C");
                    4: push_text("AT+AC");
                    5: push_text("AT+?");
                    default: push_text("AT+CH=1");
                endcase
                push_noise($urandom_range(1, 3));
            end
            foreach (burst[i]) send_byte(burst[i]);
            burst.delete();
            if ($urandom_range(99) < 4) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Generous ceiling, far above the slowest legal run with 11-beat replies.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
